@@ design/mciir_pkg.sv @@
// Shared constants, control-word types and the microcode program of the
// multichannel notch filter. Depends on nothing; the top level takes
// everything here by scoped name.
package mciir_pkg;

    // Default values of the top-level parameters.
    localparam int CHANNELS_DEF    = 4;
    localparam int SAMPLE_BITS_DEF = 16;

    // Fixed datapath widths.
    localparam int HIST_W  = 24;                 // history word
    localparam int COEF_W  = 18;                 // signed Q2.16 coefficient
    localparam int GAIN_W  = 17;                 // unsigned Q1.16 gain
    localparam int FRAC    = 16;                 // coefficient fraction bits
    localparam int PROD_W  = COEF_W + HIST_W;    // one product
    localparam int ACC_W   = 48;                 // sum of three products
    localparam int QUOT_W  = ACC_W - FRAC;       // sum after the rounding shift
    localparam int CH_W    = 2;                  // channel field
    localparam int STEP_W  = 3;                  // microcode step counter

    // Configuration port.
    localparam int CFG_IDX_W  = 5;
    localparam int CFG_DATA_W = 18;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN      = 5'd0;
    localparam logic [CFG_IDX_W-1:0] REG_POLE      = 5'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_BASE = 5'd2;

    // Register reset values.
    localparam logic [GAIN_W-1:0]        GAIN_RESET = 17'h10000;
    localparam logic signed [COEF_W-1:0] POLE_RESET = 18'sh10000;

    // Half an LSB of the result, added once into every sum so that the
    // final shift rounds half up.
    localparam logic [ACC_W-1:0] ACC_ROUND = ACC_W'(1) << (FRAC - 1);

    // Named microcode steps.
    localparam logic [STEP_W-1:0] STEP_ENTRY  = 3'd0;
    localparam logic [STEP_W-1:0] STEP_BYPASS = 3'd6;

    // Coefficient operand of the multiplier.
    typedef enum logic [1:0] {
        COEF_C = 2'd0,
        COEF_D = 2'd1,
        COEF_G = 2'd2
    } coef_sel_t;

    // History operand of the multiplier.
    typedef enum logic [1:0] {
        HIST_W1   = 2'd0,
        HIST_W2   = 2'd1,
        HIST_WNEW = 2'd2
    } hist_sel_t;

    // Accumulator operation.
    typedef enum logic [2:0] {
        ACC_HOLD      = 3'd0,
        ACC_LOAD_X    = 3'd1,
        ACC_LOAD_PROD = 3'd2,
        ACC_ADD       = 3'd3,
        ACC_SUB       = 3'd4
    } acc_op_t;

    // What the step writes into the output register.
    typedef enum logic [1:0] {
        OUT_NONE = 2'd0,
        OUT_FILT = 2'd1,
        OUT_ZERO = 2'd2
    } out_sel_t;

    // One control word of the program.
    typedef struct packed {
        coef_sel_t          coef_sel;
        hist_sel_t          hist_sel;
        logic               mul_en;
        acc_op_t            acc_op;
        logic               latch_w;
        logic               jump_bad;
        logic [STEP_W-1:0]  target;
        out_sel_t           out_sel;
        logic               last;
    } uword_t;

    // Program ROM. Each multiplying step puts one pair into the product register,
    // and each later step of the filter path folds the previous product in.
    function automatic uword_t ucode(input logic [STEP_W-1:0] step);
        uword_t w;
        w = '{coef_sel: COEF_C, hist_sel: HIST_W1, mul_en: 1'b0, acc_op: ACC_HOLD,
              latch_w: 1'b0, jump_bad: 1'b0, target: '0, out_sel: OUT_NONE,
              last: 1'b0};
        unique case (step)
            3'd0:
            begin
                // Load x, start c*w1; leave at once for a channel out of range.
                w.coef_sel = COEF_C;
                w.hist_sel = HIST_W1;
                w.mul_en   = 1'b1;
                w.acc_op   = ACC_LOAD_X;
                w.jump_bad = 1'b1;
                w.target   = STEP_BYPASS;
            end
            3'd1:
            begin
                w.coef_sel = COEF_D;
                w.hist_sel = HIST_W2;
                w.mul_en   = 1'b1;
                w.acc_op   = ACC_SUB;
            end
            3'd2:
            begin
                w.coef_sel = COEF_G;
                w.hist_sel = HIST_W2;
                w.mul_en   = 1'b1;
                w.acc_op   = ACC_SUB;
            end
            3'd3:
            begin
                // The recursion sum is complete: round it into w.
                w.coef_sel = COEF_C;
                w.hist_sel = HIST_W1;
                w.mul_en   = 1'b1;
                w.acc_op   = ACC_LOAD_PROD;
                w.latch_w  = 1'b1;
            end
            3'd4:
            begin
                w.coef_sel = COEF_G;
                w.hist_sel = HIST_WNEW;
                w.mul_en   = 1'b1;
                w.acc_op   = ACC_ADD;
            end
            3'd5:
            begin
                w.out_sel = OUT_FILT;
                w.last    = 1'b1;
            end
            default:
            begin
                // Bypass: the result carries zero and no state changes.
                w.out_sel = OUT_ZERO;
                w.last    = 1'b1;
            end
        endcase
        return w;
    endfunction

    // Saturate a rounded sum to a signed history word.
    function automatic logic signed [HIST_W-1:0] sat_hist(
        input logic signed [QUOT_W-1:0] v
    );
        logic fits;
        logic signed [HIST_W-1:0] r;
        fits = (&v[QUOT_W-1:HIST_W-1]) || (~|v[QUOT_W-1:HIST_W-1]);
        if (fits)
        begin
            r = v[HIST_W-1:0];
        end
        else if (v[QUOT_W-1])
        begin
            r = {1'b1, {(HIST_W-1){1'b0}}};
        end
        else
        begin
            r = {1'b0, {(HIST_W-1){1'b1}}};
        end
        return r;
    endfunction

endpackage

@@ design/multichannel_iir_notch_biquad.sv @@
// Multichannel Direct Form II notch filter: configuration registers, per-channel
// history, a microcoded sequencer and a shared 18x24 multiplier datapath.
// Depends on mciir_pkg.

// Each word names a channel and carries one signed Q1.15 sample; the block
// returns one word per input with the same channel and the notch-filtered,
// saturated sample. The block captures a word and then runs six microcode
// steps, set by the five products that share the single multiplier, before
// it can accept the next one. A word whose channel is not below CHANNELS
// jumps to the bypass step and returns zero. The input is stalled while a
// word is in work; the finished result sits in an output register, so the
// next word is taken while it waits. Gain, pole term and
// the per-channel centre coefficients are written through the configuration
// port while the block is idle; writing a centre coefficient clears that
// channel's history.
module multichannel_iir_notch_biquad #(
    parameter int CHANNELS    = mciir_pkg::CHANNELS_DEF,
    parameter int SAMPLE_BITS = mciir_pkg::SAMPLE_BITS_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    // Input channel
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic [mciir_pkg::CH_W-1:0]            channel,
    input  logic signed [SAMPLE_BITS-1:0]         sample_in,
    // Output channel
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic [mciir_pkg::CH_W-1:0]            channel_out,
    output logic signed [SAMPLE_BITS-1:0]         sample_out,
    // Configuration write channel
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [mciir_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [mciir_pkg::CFG_DATA_W-1:0]      cfg_data
);

    localparam int HIST_W = mciir_pkg::HIST_W;
    localparam int COEF_W = mciir_pkg::COEF_W;
    localparam int PROD_W = mciir_pkg::PROD_W;
    localparam int ACC_W  = mciir_pkg::ACC_W;
    localparam int FRAC   = mciir_pkg::FRAC;
    localparam int QUOT_W = mciir_pkg::QUOT_W;
    localparam int XPAD   = ACC_W - SAMPLE_BITS - FRAC;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_RUN  = 2'b10
    } state_t;

    // Configuration registers.
    logic [mciir_pkg::GAIN_W-1:0]   gain_reg;
    logic signed [COEF_W-1:0]       pole_reg;
    logic signed [COEF_W-1:0]       coef_reg [CHANNELS];

    // Per-channel history.
    logic signed [HIST_W-1:0]       hist_newer_reg [CHANNELS];
    logic signed [HIST_W-1:0]       hist_older_reg [CHANNELS];

    // Sequencer.
    state_t                          state_reg, state_next;
    logic [mciir_pkg::STEP_W-1:0]    step_reg, step_next;
    mciir_pkg::uword_t               uw;

    // Working registers of the word in progress.
    logic [mciir_pkg::CH_W-1:0]      ch_reg;
    logic signed [SAMPLE_BITS-1:0]   x_reg;
    logic signed [COEF_W-1:0]        c_op_reg;
    logic signed [HIST_W-1:0]        w1_reg;
    logic signed [HIST_W-1:0]        w2_reg;
    logic signed [HIST_W-1:0]        w_reg;
    logic signed [PROD_W-1:0]        prod_reg;
    logic signed [ACC_W-1:0]         acc_reg;

    // Output register.
    logic                            out_valid_reg;
    logic [mciir_pkg::CH_W-1:0]      channel_out_reg;
    logic signed [SAMPLE_BITS-1:0]   sample_out_reg;

    // Combinational signals.
    logic                            in_accept;
    logic                            cfg_write;
    logic                            ch_bad;
    logic                            out_free;
    logic                            running;
    logic                            emit;
    logic                            hist_write;
    logic signed [COEF_W-1:0]        sel_c;
    logic signed [HIST_W-1:0]        sel_w1;
    logic signed [HIST_W-1:0]        sel_w2;
    logic signed [COEF_W-1:0]        mul_a;
    logic signed [HIST_W-1:0]        mul_b;
    logic signed [PROD_W-1:0]        prod_next;
    logic signed [ACC_W-1:0]         prod_ext;
    logic signed [ACC_W-1:0]         x_ext;
    logic signed [ACC_W-1:0]         acc_next;
    logic signed [ACC_W-1:0]         y_sum;
    logic signed [QUOT_W-1:0]        y_quot;
    logic signed [SAMPLE_BITS-1:0]   y_sat;
    logic                            y_fits;

    // Handshake.
    assign in_stall    = (state_reg != ST_IDLE);
    assign cfg_ready   = (state_reg == ST_IDLE);
    assign in_accept   = in_valid && !in_stall;
    assign cfg_write   = cfg_valid && cfg_ready;
    assign out_valid   = out_valid_reg;
    assign channel_out = channel_out_reg;
    assign sample_out  = sample_out_reg;

    // Current control word.
    assign uw         = mciir_pkg::ucode(step_reg);
    assign running    = (state_reg == ST_RUN);
    assign ch_bad     = (int'(ch_reg) >= CHANNELS);
    assign out_free   = !out_valid_reg || !out_stall;
    assign emit       = running && (uw.out_sel != mciir_pkg::OUT_NONE) && out_free;
    assign hist_write = emit && (uw.out_sel == mciir_pkg::OUT_FILT);

    // Read the addressed channel's coefficient and history at acceptance.
    always_comb
    begin
        sel_c  = '0;
        sel_w1 = '0;
        sel_w2 = '0;
        for (int i = 0; i < CHANNELS; i++)
        begin
            if (int'(channel) == i)
            begin
                sel_c  = coef_reg[i];
                sel_w1 = hist_newer_reg[i];
                sel_w2 = hist_older_reg[i];
            end
        end
    end

    // Sequencer next state.
    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_RUN;
                    step_next  = mciir_pkg::STEP_ENTRY;
                end
            end
            ST_RUN:
            begin
                if (uw.jump_bad && ch_bad)
                begin
                    step_next = uw.target;
                end
                else if (uw.last)
                begin
                    if (out_free)
                    begin
                        state_next = ST_IDLE;
                    end
                end
                else
                begin
                    step_next = step_reg + 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= mciir_pkg::STEP_ENTRY;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    // Multiplier operand selection.
    always_comb
    begin
        case (uw.coef_sel)
            mciir_pkg::COEF_C: mul_a = c_op_reg;
            mciir_pkg::COEF_D: mul_a = pole_reg;
            mciir_pkg::COEF_G: mul_a = signed'({1'b0, gain_reg});
            default:           mul_a = '0;
        endcase
        case (uw.hist_sel)
            mciir_pkg::HIST_W1:   mul_b = w1_reg;
            mciir_pkg::HIST_W2:   mul_b = w2_reg;
            mciir_pkg::HIST_WNEW: mul_b = w_reg;
            default:              mul_b = '0;
        endcase
    end

    assign prod_next = mul_a * mul_b;
    assign prod_ext  = {{(ACC_W-PROD_W){prod_reg[PROD_W-1]}}, prod_reg};
    assign x_ext     = {{XPAD{x_reg[SAMPLE_BITS-1]}}, x_reg, {FRAC{1'b0}}}
                       | signed'(mciir_pkg::ACC_ROUND);

    // Accumulator operation.
    always_comb
    begin
        case (uw.acc_op)
            mciir_pkg::ACC_LOAD_X:    acc_next = x_ext;
            mciir_pkg::ACC_LOAD_PROD: acc_next = prod_ext + signed'(mciir_pkg::ACC_ROUND);
            mciir_pkg::ACC_ADD:       acc_next = acc_reg + prod_ext;
            mciir_pkg::ACC_SUB:       acc_next = acc_reg - prod_ext;
            default:                  acc_next = acc_reg;
        endcase
    end

    // Output sum: round by shifting out the fraction, then saturate.
    assign y_sum  = acc_reg + prod_ext;
    assign y_quot = y_sum[ACC_W-1:FRAC];
    assign y_fits = (&y_quot[QUOT_W-1:SAMPLE_BITS-1]) || (~|y_quot[QUOT_W-1:SAMPLE_BITS-1]);

    always_comb
    begin
        if (y_fits)
        begin
            y_sat = y_quot[SAMPLE_BITS-1:0];
        end
        else if (y_quot[QUOT_W-1])
        begin
            y_sat = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
        end
        else
        begin
            y_sat = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
        end
    end

    // Working registers of the datapath.
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            ch_reg   <= channel;
            x_reg    <= sample_in;
            c_op_reg <= sel_c;
            w1_reg   <= sel_w1;
            w2_reg   <= sel_w2;
        end
        if (running && uw.mul_en)
        begin
            prod_reg <= prod_next;
        end
        if (running)
        begin
            acc_reg <= acc_next;
        end
        if (running && uw.latch_w)
        begin
            w_reg <= mciir_pkg::sat_hist(acc_reg[ACC_W-1:FRAC]);
        end
    end

    // Configuration registers and history.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg <= mciir_pkg::GAIN_RESET;
            pole_reg <= mciir_pkg::POLE_RESET;
            for (int i = 0; i < CHANNELS; i++)
            begin
                coef_reg[i]       <= '0;
                hist_newer_reg[i] <= '0;
                hist_older_reg[i] <= '0;
            end
        end
        else
        begin
            if (cfg_write && (cfg_index == mciir_pkg::REG_GAIN))
            begin
                gain_reg <= cfg_data[mciir_pkg::GAIN_W-1:0];
            end
            if (cfg_write && (cfg_index == mciir_pkg::REG_POLE))
            begin
                pole_reg <= signed'(cfg_data[COEF_W-1:0]);
            end
            for (int i = 0; i < CHANNELS; i++)
            begin
                if (cfg_write && (int'(cfg_index) == int'(mciir_pkg::REG_COEF_BASE) + i))
                begin
                    coef_reg[i]       <= signed'(cfg_data[COEF_W-1:0]);
                    hist_newer_reg[i] <= '0;
                    hist_older_reg[i] <= '0;
                end
                else if (hist_write && (int'(ch_reg) == i))
                begin
                    hist_newer_reg[i] <= w_reg;
                    hist_older_reg[i] <= w1_reg;
                end
            end
        end
    end

    // Output register valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Output register payload.
    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            channel_out_reg <= ch_reg;
            sample_out_reg  <= (uw.out_sel == mciir_pkg::OUT_FILT) ? y_sat : '0;
        end
    end

    // An accepted word always starts the program at its entry step.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> (state_reg == ST_RUN) && (step_reg == mciir_pkg::STEP_ENTRY))
    else $error("accepted word did not start the program at its entry step");

    // A final step that finds the output free delivers and returns to idle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (running && uw.last && out_free) |=> (out_valid_reg && (state_reg == ST_IDLE)))
    else $error("final step did not deliver its result");

    // Writing channel zero's centre coefficient clears its history.
    assert property (@(posedge clk) disable iff (!rst_n)
        (cfg_write && (cfg_index == mciir_pkg::REG_COEF_BASE))
        |=> ((hist_newer_reg[0] == '0) && (hist_older_reg[0] == '0)))
    else $error("centre coefficient write did not clear the history");

endmodule
